@@ hdl/tkn_pkg.sv @@
package tkn_pkg;

  localparam int FEATURE_DIM_DEF = 1024;
  localparam int K_MAX_DEF       = 64;
  localparam int DIST_W          = 48;
  localparam int ID_W            = 32;
  localparam int KW              = 7;
  localparam int IDX_W           = 10;
  localparam int QV_W            = 16;
  localparam int RANK_W          = 6;
  localparam logic [KW-1:0] K_RESET = 7'd16;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_DATA  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_ENTRY  = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [ID_W-1:0]   did;
    logic [ID_W-1:0]   cid;
  } entry_t;

  function automatic logic [DIST_W-1:0] sat_add48(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
  endfunction

endpackage

@@ hdl/tkn_qram.sv @@
module tkn_qram import tkn_pkg::*; #(
  parameter int DEPTH = FEATURE_DIM_DEF,
  parameter int AW    = $clog2(FEATURE_DIM_DEF)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic signed [QV_W-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic signed [QV_W-1:0] rdata
);

  logic signed [QV_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/tkn_lram.sv @@
module tkn_lram import tkn_pkg::*; #(
  parameter int DEPTH = K_MAX_DEF,
  parameter int AW    = $clog2(K_MAX_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/top_k_nearest_sparse_distance_core.sv @@
// Channel   | Ports                                                  | Handshake
// request   | command feature_index feature_value descriptor_id      | start & !busy
//           | cluster_id last_feature                                |
// result    | kind distance out_descriptor_id out_cluster_id         | done, one cycle
//           | accepted rank last_result                              |
// config    | k_in_use_wdata                                         | k_in_use_we
//
// Request steps: load query reads the query memory, then S_QMUL and S_QUPD; a data
// feature passes S_DMUL and S_DACC, and a last one goes on through S_DFIN, S_CHK,
// S_CHKW when the list is full (a rejected descriptor ends there), then S_SRD and
// S_SCMP once per list entry shifted down; read list runs S_LIST per entry, S_LDRN.
// Clear, and reset, sweep the query memory, zeroing every address with busy high.
// Query memory and neighbour list are single-port-read synchronous RAMs; the
// read-modify-write of each request is serialized by the control FSM.
// Results cannot be stalled: done pulses once per result.
module top_k_nearest_sparse_distance_core import tkn_pkg::*; #(
  parameter int FEATURE_DIM = FEATURE_DIM_DEF,
  parameter int K_MAX       = K_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command,
  input  logic [IDX_W-1:0]         feature_index,
  input  logic signed [QV_W-1:0]   feature_value,
  input  logic [ID_W-1:0]          descriptor_id,
  input  logic [ID_W-1:0]          cluster_id,
  input  logic                     last_feature,
  input  logic                     k_in_use_we,
  input  logic [KW-1:0]            k_in_use_wdata,
  output logic                     done,
  output logic                     kind,
  output logic [DIST_W-1:0]        distance,
  output logic [ID_W-1:0]          out_descriptor_id,
  output logic [ID_W-1:0]          out_cluster_id,
  output logic                     accepted,
  output logic [RANK_W-1:0]        rank,
  output logic                     last_result
);

  localparam int QAW = $clog2(FEATURE_DIM);
  localparam int LAW = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  typedef enum logic [12:0] {
    S_IDLE = 13'b0000000000001,
    S_CLR  = 13'b0000000000010,
    S_QMUL = 13'b0000000000100,
    S_QUPD = 13'b0000000001000,
    S_DMUL = 13'b0000000010000,
    S_DACC = 13'b0000000100000,
    S_DFIN = 13'b0000001000000,
    S_CHK  = 13'b0000010000000,
    S_CHKW = 13'b0000100000000,
    S_SRD  = 13'b0001000000000,
    S_SCMP = 13'b0010000000000,
    S_LIST = 13'b0100000000000,
    S_LDRN = 13'b1000000000000
  } state_t;

  state_t state;

  // held request
  logic [QAW-1:0]         h_addr;
  logic                   h_inrange;
  logic signed [QV_W-1:0] h_val;
  logic [ID_W-1:0]        h_did, h_cid;
  logic                   h_last;

  logic [KW-1:0]     k_in_use;
  logic [QAW-1:0]    clr_cnt;
  logic [31:0]       a_sq, b_sq;
  logic [DIST_W-1:0] energy, partial, matched, cur_dist;
  logic [KW-1:0]     filled, ins_i, rd_r;

  // list read pipeline
  logic              p1_v, p1_ok, p1_last;
  logic [RANK_W-1:0] p1_rank;

  // query memory
  logic                   q_we;
  logic [QAW-1:0]         q_waddr, q_raddr;
  logic signed [QV_W-1:0] q_wdata, q_rdata;

  // list memory
  logic           l_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  entry_t         l_wdata, l_rdata, new_ent;

  logic [KW-1:0] kk, n_fill;
  logic          in_range, shift_down, rep_fire, rep_acc;
  logic [KW-1:0] rep_rank;
  logic signed [QV_W-1:0]   q_eff;
  logic signed [QV_W:0]     d_val;
  logic signed [2*QV_W+1:0] d_prod;
  logic signed [2*QV_W-1:0] q_prod, o_prod, n_prod;

  assign busy = (state != S_IDLE);

  always_comb begin
    kk = k_in_use;
    if (kk == '0) kk = KW'(1);
    if (kk > KW'(K_MAX)) kk = KW'(K_MAX);
  end

  assign n_fill   = (filled < kk) ? filled : kk;
  assign in_range = ({{(32-IDX_W){1'b0}}, feature_index} < 32'(FEATURE_DIM));
  assign new_ent  = '{sq_dist: cur_dist, did: h_did, cid: h_cid};
  assign shift_down = (l_rdata.sq_dist > cur_dist);

  // squares of the held value against the stored query value
  assign q_eff  = h_inrange ? q_rdata : '0;
  assign d_val  = {h_val[QV_W-1], h_val} - {q_eff[QV_W-1], q_eff};
  assign d_prod = d_val * d_val;
  assign q_prod = q_eff * q_eff;
  assign o_prod = q_rdata * q_rdata;
  assign n_prod = h_val * h_val;

  always_comb begin
    q_raddr = QAW'(feature_index);
    q_we    = 1'b0;
    q_waddr = h_addr;
    q_wdata = h_val;
    l_raddr = '0;
    l_we    = 1'b0;
    l_waddr = ins_i[LAW-1:0];
    l_wdata = new_ent;
    rep_fire = 1'b0;
    rep_acc  = 1'b1;
    rep_rank = ins_i;
    case (state)
      S_CLR: begin
        q_we    = 1'b1;
        q_waddr = clr_cnt;
        q_wdata = '0;
      end
      S_QUPD: begin
        q_we = h_inrange;
      end
      S_CHK: begin
        l_raddr = LAW'(kk - KW'(1));
      end
      S_CHKW: begin
        if (!(cur_dist < l_rdata.sq_dist)) begin
          rep_fire = 1'b1;
          rep_acc  = 1'b0;
          rep_rank = '0;
        end
      end
      S_SRD: begin
        l_raddr = LAW'(ins_i - KW'(1));
        if (ins_i == '0) begin
          l_we     = 1'b1;
          rep_fire = 1'b1;
        end
      end
      S_SCMP: begin
        l_we = 1'b1;
        if (shift_down) begin
          l_wdata = l_rdata;
        end else begin
          rep_fire = 1'b1;
        end
      end
      S_LIST: begin
        l_raddr = rd_r[LAW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    p1_v <= 1'b0;
    if (k_in_use_we) begin
      k_in_use <= k_in_use_wdata;
    end
    // report for a scored descriptor
    if (rep_fire) begin
      done              <= 1'b1;
      kind              <= KIND_REPORT;
      distance          <= cur_dist;
      out_descriptor_id <= h_did;
      out_cluster_id    <= h_cid;
      accepted          <= rep_acc;
      rank              <= rep_rank[RANK_W-1:0];
      last_result       <= 1'b1;
      if (rep_acc) begin
        filled <= (n_fill < kk) ? n_fill + KW'(1) : kk;
      end
      state <= S_IDLE;
    end
    // list entry, from the list RAM data read in step with the p1 stage
    if (p1_v) begin
      done              <= 1'b1;
      kind              <= KIND_ENTRY;
      distance          <= p1_ok ? l_rdata.sq_dist : '0;
      out_descriptor_id <= p1_ok ? l_rdata.did : '0;
      out_cluster_id    <= p1_ok ? l_rdata.cid : '0;
      accepted          <= p1_ok;
      rank              <= p1_rank;
      last_result       <= p1_last;
    end
    case (state)
      S_IDLE: begin
        if (start) begin
          h_addr    <= QAW'(feature_index);
          h_inrange <= in_range;
          h_val     <= feature_value;
          h_did     <= descriptor_id;
          h_cid     <= cluster_id;
          h_last    <= last_feature;
          rd_r      <= '0;
          clr_cnt   <= '0;
          case (cmd_t'(command))
            CMD_CLEAR: begin
              energy  <= '0;
              partial <= '0;
              matched <= '0;
              filled  <= '0;
              state   <= S_CLR;
            end
            CMD_LOAD: state <= S_QMUL;
            CMD_DATA: state <= S_DMUL;
            CMD_READ: state <= S_LIST;
            default:  state <= S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        clr_cnt <= clr_cnt + QAW'(1);
        if (clr_cnt == QAW'(FEATURE_DIM - 1)) state <= S_IDLE;
      end
      S_QMUL: begin
        a_sq  <= 32'(o_prod);
        b_sq  <= 32'(n_prod);
        state <= S_QUPD;
      end
      S_QUPD: begin
        if (h_inrange) energy <= energy - DIST_W'(a_sq) + DIST_W'(b_sq);
        state <= S_IDLE;
      end
      S_DMUL: begin
        a_sq  <= d_prod[31:0];
        b_sq  <= 32'(q_prod);
        state <= S_DACC;
      end
      S_DACC: begin
        partial <= sat_add48(partial, DIST_W'(a_sq));
        matched <= sat_add48(matched, DIST_W'(b_sq));
        state   <= h_last ? S_DFIN : S_IDLE;
      end
      S_DFIN: begin
        cur_dist <= sat_add48(partial, (energy > matched) ? energy - matched : '0);
        partial  <= '0;
        matched  <= '0;
        state    <= S_CHK;
      end
      S_CHK: begin
        // list not full: insert; full: compare against the worst entry first
        if (n_fill < kk) begin
          ins_i <= n_fill;
          state <= S_SRD;
        end else begin
          state <= S_CHKW;
        end
      end
      S_CHKW: begin
        if (cur_dist < l_rdata.sq_dist) begin
          ins_i <= kk - KW'(1);
          state <= S_SRD;
        end
      end
      S_SRD: begin
        if (ins_i != '0) state <= S_SCMP;
      end
      S_SCMP: begin
        // entry above is farther: it moved down one slot, keep walking up
        if (shift_down) begin
          ins_i <= ins_i - KW'(1);
          state <= S_SRD;
        end
      end
      S_LIST: begin
        p1_v    <= 1'b1;
        p1_ok   <= (rd_r < filled);
        p1_rank <= rd_r[RANK_W-1:0];
        p1_last <= (rd_r == kk - KW'(1));
        rd_r    <= rd_r + KW'(1);
        if (rd_r == kk - KW'(1)) state <= S_LDRN;
      end
      S_LDRN: state <= S_IDLE;
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      k_in_use <= K_RESET;
      energy   <= '0;
      partial  <= '0;
      matched  <= '0;
      filled   <= '0;
      done     <= 1'b0;
      p1_v     <= 1'b0;
    end
  end

  tkn_qram #(.DEPTH(FEATURE_DIM), .AW(QAW)) u_qram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  tkn_lram #(.DEPTH(K_MAX), .AW(LAW)) u_lram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

endmodule
